// File: hw/rtl/kwm_pkg.sv
// Package for the k-way sorted merge: shared types and fixed constants.
`default_nettype none

package kwm_pkg;

  // Width of the list count register and of the source field on the result
  localparam int CFG_W      = 5;
  localparam int SRC_OUT_W  = 4;
  localparam logic [CFG_W-1:0] LIST_COUNT_RESET = 5'd16;

  // Per-cycle command broadcast to every cell of the sorted chain
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/kwm_cell.sv
// One cell of the sorted chain: holds one (value, list) entry in ascending order.
`default_nettype none

module kwm_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int SRC_W      = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire kwm_pkg::cell_ctrl_t     ctrl,
  input  wire logic [DATA_WIDTH-1:0]   ins_val,
  input  wire logic [SRC_W-1:0]        ins_src,
  input  wire logic                    left_valid,
  input  wire logic                    left_lt,
  input  wire logic [DATA_WIDTH-1:0]   left_val,
  input  wire logic [SRC_W-1:0]        left_src,
  input  wire logic                    right_valid,
  input  wire logic [DATA_WIDTH-1:0]   right_val,
  input  wire logic [SRC_W-1:0]        right_src,
  output logic                         valid,
  output logic [DATA_WIDTH-1:0]        val,
  output logic [SRC_W-1:0]             src,
  output logic                         lt
);
  import kwm_pkg::*;

  logic val_lt;
  logic val_eq;

  // New entry sorts ahead of this one; an empty cell counts as infinity
  assign val_lt = $signed(ins_val) < $signed(val);
  assign val_eq = ins_val == val;
  assign lt     = !valid || val_lt || (val_eq && (ins_src < src));

  // Fill only the first empty cell on an insert: its left neighbour holds an entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.insert && left_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      val <= right_val;
      src <= right_src;
    end else if (ctrl.insert) begin
      // Shift right where the left neighbour is displaced, take new at the gap
      if (left_lt) begin
        val <= left_val;
        src <= left_src;
      end else if (lt) begin
        val <= ins_val;
        src <= ins_src;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/k_way_sorted_merge.sv
// An accepted input beat is inserted into the cell chain and, where it asks for a
// result, sets pop_pending; the pop of the head cell then goes into the output
// register. No input beat is taken while a pop is pending; a held result delays it.
// Load-phase beats before the last head give no result beat and can follow every cycle.
// Reset: queue emptied, load phase, heads count zero, list_count set to 16.
`default_nettype none

module k_way_sorted_merge #(
  parameter int MAX_LISTS  = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_WIDTH + kwm_pkg::SRC_OUT_W + 7) / 8) * 8
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire logic [IN_W-1:0]            s_tdata,   // value
  input  wire logic [0:0]                 s_tuser,   // present
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [OUT_W-1:0]                m_tdata,   // merged_value, source_list
  output logic [0:0]                      m_tuser,   // done_res
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [kwm_pkg::CFG_W-1:0]  cfg_data   // list_count
);
  import kwm_pkg::*;

  localparam int SRC_W = $clog2(MAX_LISTS);
  localparam int CW    = $clog2(MAX_LISTS + 1);
  localparam int CMPW  = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]      list_count;
  logic                  merging;
  logic [CW-1:0]         heads_loaded;
  logic [CW-1:0]         heads_loaded_next;
  logic [SRC_W-1:0]      req_list;
  logic                  pop_pending;
  logic                  s_fire;
  logic                  do_pop;
  logic                  pop_req;
  logic [DATA_WIDTH-1:0] ins_val;
  logic [SRC_W-1:0]      ins_src;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] out_val;
  logic [SRC_W-1:0]      out_src;
  logic                  out_done;

  logic                  cell_valid [MAX_LISTS];
  logic [DATA_WIDTH-1:0] cell_val   [MAX_LISTS];
  logic [SRC_W-1:0]      cell_src   [MAX_LISTS];
  logic                  cell_lt    [MAX_LISTS];

  assign cfg_ready = 1'b1;
  assign s_tready  = !pop_pending;
  assign s_fire    = s_tvalid && s_tready;
  assign do_pop    = pop_pending && (!m_tvalid || m_tready);

  assign ins_val = s_tdata[DATA_WIDTH-1:0];
  assign ins_src = merging ? req_list : heads_loaded[SRC_W-1:0];

  assign ctrl = '{insert: s_fire && s_tuser[0], pop: do_pop && cell_valid[0]};

  // Saturating head count; a zero list count behaves as one
  assign heads_loaded_next = (heads_loaded == CW'(MAX_LISTS)) ? heads_loaded
                                                               : heads_loaded + CW'(1);
  assign pop_req = merging
                || (CMPW'(heads_loaded_next) >= CMPW'(list_count))
                || (heads_loaded_next == CW'(MAX_LISTS));

  genvar g;
  generate
    for (g = 0; g < MAX_LISTS; g++) begin : g_cell
      logic                  l_valid;
      logic                  l_lt;
      logic [DATA_WIDTH-1:0] l_val;
      logic [SRC_W-1:0]      l_src;
      logic                  r_valid;
      logic [DATA_WIDTH-1:0] r_val;
      logic [SRC_W-1:0]      r_src;

      if (g == 0) begin : g_first
        assign l_valid = 1'b1;
        assign l_lt    = 1'b0;
        assign l_val   = '0;
        assign l_src   = '0;
      end else begin : g_mid
        assign l_valid = cell_valid[g-1];
        assign l_lt    = cell_lt[g-1];
        assign l_val   = cell_val[g-1];
        assign l_src   = cell_src[g-1];
      end

      if (g == MAX_LISTS - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_val   = '0;
        assign r_src   = '0;
      end else begin : g_inner
        assign r_valid = cell_valid[g+1];
        assign r_val   = cell_val[g+1];
        assign r_src   = cell_src[g+1];
      end

      kwm_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .SRC_W      (SRC_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .ins_val     (ins_val),
        .ins_src     (ins_src),
        .left_valid  (l_valid),
        .left_lt     (l_lt),
        .left_val    (l_val),
        .left_src    (l_src),
        .right_valid (r_valid),
        .right_val   (r_val),
        .right_src   (r_src),
        .valid       (cell_valid[g]),
        .val         (cell_val[g]),
        .src         (cell_src[g]),
        .lt          (cell_lt[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count <= LIST_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      list_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      merging      <= 1'b0;
      heads_loaded <= '0;
      req_list     <= '0;
      pop_pending  <= 1'b0;
    end else if (do_pop) begin
      pop_pending <= 1'b0;
      if (cell_valid[0]) begin
        merging  <= 1'b1;
        req_list <= cell_src[0];
      end else begin
        // Queue drained: back to loading heads
        merging      <= 1'b0;
        heads_loaded <= '0;
        req_list     <= '0;
      end
    end else if (s_fire) begin
      pop_pending <= pop_req;
      if (!merging) begin
        heads_loaded <= heads_loaded_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (cell_valid[0]) begin
        out_val  <= cell_val[0];
        out_src  <= cell_src[0];
        out_done <= 1'b0;
      end else begin
        out_val  <= '0;
        out_src  <= '0;
        out_done <= 1'b1;
      end
    end
  end

  assign m_tdata    = OUT_W'({SRC_OUT_W'(out_src), out_val});
  assign m_tuser[0] = out_done;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the k-way sorted merge: directed and random list sets.
`timescale 1ns / 1ps

module testbench;
  import kwm_pkg::*;

  localparam int LISTS        = 16;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    logic signed [31:0] value;
    logic               present;
  } elem_t;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         list;
    logic               done;
  } merged_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;    // value
  logic [0:0]       s_tuser = '0;    // present
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [39:0]      m_tdata;         // merged_value, source_list
  logic [0:0]       m_tuser;         // done_res
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;   // list_count

  k_way_sorted_merge i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  elem_t   elem_feed[$];
  merged_t merged_due[$];
  merged_t due;
  int      mismatches   = 0;
  int      fed_total    = 0;
  int      send_gap_pct = 0;
  int      stall_pct    = 0;
  int      quiet_cycles = 0;

  // Predicted block state
  logic signed [31:0] pq_value [LISTS];
  logic [3:0]         pq_list  [LISTS];
  int unsigned        pq_fill     = 0;
  bit                 pq_merging  = 1'b0;
  int unsigned        pq_heads    = 0;
  logic [3:0]         pq_next     = '0;
  logic [CFG_W-1:0]   pq_count    = LIST_COUNT_RESET;

  function automatic int active_lists(logic [CFG_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > LISTS) return LISTS;
    return int'(cnt);
  endfunction

  function automatic void pq_insert(logic signed [31:0] v, logic [3:0] src);
    if (pq_fill < LISTS) begin
      pq_value[pq_fill] = v;
      pq_list[pq_fill]  = src;
      pq_fill++;
    end
  endfunction

  // Append one expected result beat
  function automatic void due_add(logic signed [31:0] v, logic [3:0] l, logic d);
    merged_t m;
    m.value = v;
    m.list  = l;
    m.done  = d;
    merged_due.insert(merged_due.size(), m);
  endfunction

  // Remove the smallest entry, lower list on a tie; an empty queue ends the merge
  function automatic void pq_pop_emit();
    int unsigned best;
    best = 0;
    if (pq_fill == 0) begin
      pq_merging = 1'b0;
      pq_heads   = 0;
      pq_next    = '0;
      due_add(32'sd0, 4'd0, 1'b1);
      return;
    end
    for (int unsigned i = 1; i < pq_fill; i++) begin
      if (pq_value[i] < pq_value[best] ||
          (pq_value[i] == pq_value[best] && pq_list[i] < pq_list[best]))
        best = i;
    end
    due_add(pq_value[best], pq_list[best], 1'b0);
    pq_next = pq_list[best];
    pq_fill--;
    pq_value[best] = pq_value[pq_fill];
    pq_list[best]  = pq_list[pq_fill];
    pq_merging = 1'b1;
  endfunction

  function automatic void advance_merge(logic signed [31:0] v, logic present);
    if (!pq_merging) begin
      if (present) pq_insert(v, pq_heads[3:0]);
      if (pq_heads < LISTS) pq_heads++;
      if (pq_heads < active_lists(pq_count)) return;
    end else if (present) begin
      pq_insert(v, pq_next);
    end
    pq_pop_emit();
  endfunction

  function automatic void queue_elem(logic signed [31:0] v, logic present);
    elem_t e;
    e.value   = v;
    e.present = present;
    elem_feed.insert(elem_feed.size(), e);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2, 3, 4: begin
        v = $urandom_range(0, 8);
        v = v - 32'sd4;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Build one list set and queue the beats in the order the merge requests them
  function automatic void build_frame(int n, bit ordered);
    logic signed [31:0] vals [LISTS][6];
    logic signed [31:0] t;
    int                 lens [LISTS];
    int                 ptr  [LISTS];
    bit                 live [LISTS];
    int                 p;
    int                 j;
    for (int l = 0; l < n; l++) begin
      lens[l] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < lens[l]; i++) vals[l][i] = pick_value();
      if (ordered) begin
        for (int i = 1; i < lens[l]; i++) begin
          t = vals[l][i];
          j = i - 1;
          while (j >= 0 && vals[l][j] > t) begin
            vals[l][j + 1] = vals[l][j];
            j--;
          end
          vals[l][j + 1] = t;
        end
      end
      live[l] = (lens[l] != 0);
      ptr[l]  = 1;
      queue_elem(live[l] ? vals[l][0] : $urandom, live[l]);
      fed_total++;
    end
    forever begin
      p = -1;
      for (int l = 0; l < n; l++) begin
        if (live[l] && (p < 0 || vals[l][ptr[l] - 1] < vals[p][ptr[p] - 1])) p = l;
      end
      if (p < 0) break;
      if (ptr[p] < lens[p]) begin
        queue_elem(vals[p][ptr[p]], 1'b1);
        ptr[p]++;
      end else begin
        queue_elem($urandom, 1'b0);
        live[p] = 1'b0;
      end
      fed_total++;
    end
  endfunction

  // Hold until every beat is in and every result out, then let the pipeline drain
  task automatic settle();
    while (elem_feed.size() != 0 || merged_due.size() != 0 || s_tvalid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] cnt);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pq_count = cnt;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_merge(s_tdata, s_tuser[0]);
        elem_feed.delete(0);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (elem_feed.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= elem_feed[0].value;
          s_tuser  <= elem_feed[0].present;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (merged_due.size() == 0) begin
        $error("unexpected result beat: merged_value %0d source_list %0d done_res %0d",
               $signed(m_tdata[31:0]), m_tdata[35:32], m_tuser[0]);
        mismatches++;
      end else begin
        due = merged_due.pop_front();
        if (m_tdata[31:0] !== due.value) begin
          $error("merged_value: expected %0d, actual %0d", due.value, $signed(m_tdata[31:0]));
          mismatches++;
        end
        if (m_tdata[35:32] !== due.list) begin
          $error("source_list: expected %0d, actual %0d", due.list, m_tdata[35:32]);
          mismatches++;
        end
        if (m_tuser[0] !== due.done) begin
          $error("done_res: expected %0d, actual %0d", due.done, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("k_way_sorted_merge verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               phase;
    int               frames;
    logic [CFG_W-1:0] cnt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Zero count behaves as one list: extremes through a single list
    write_count(5'd0);
    queue_elem(32'sh8000_0000, 1'b1);
    queue_elem(32'sh7fff_ffff, 1'b1);
    queue_elem(32'sh0000_1234, 1'b0);
    // Empty list on its own ends the merge at once
    queue_elem(32'shffff_ffff, 1'b0);
    settle();

    // Equal values across lists: lower list wins
    write_count(5'd3);
    queue_elem(32'sd5, 1'b1);
    queue_elem(32'sd5, 1'b1);
    queue_elem(-32'sd1, 1'b1);
    queue_elem(32'sd5, 1'b1);
    queue_elem(32'sd0, 1'b0);
    queue_elem(32'sd0, 1'b0);
    queue_elem(32'sd0, 1'b0);
    settle();

    // Lower the count part way through loading: merge starts on the next head
    write_count(5'd16);
    queue_elem(32'sd7, 1'b1);
    queue_elem(32'sd9, 1'b0);
    queue_elem(-32'sd3, 1'b1);
    queue_elem(32'sd0, 1'b1);
    settle();
    write_count(5'd2);
    queue_elem(32'sd1, 1'b1);
    repeat (4) queue_elem(32'sd0, 1'b0);
    settle();

    phase = 0;
    while (fed_total < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 67; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 67; end
        default: begin send_gap_pct = 8; stall_pct = 8; end
      endcase
      case (phase)
        0: cnt = 5'd16;
        1: cnt = 5'd1;
        2: cnt = 5'd31;
        3: cnt = 5'd0;
        4: cnt = 5'd2;
        5: cnt = 5'd17;
        default: cnt = CFG_W'($urandom_range(0, 31));
      endcase
      write_count(cnt);
      frames = $urandom_range(1, 3);
      repeat (frames) build_frame(active_lists(cnt), $urandom_range(0, 4) != 0);
      settle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("k_way_sorted_merge verification clean");
    end else begin
      $display("k_way_sorted_merge verification failed");
    end
    $finish;
  end

endmodule
